// ----- rtl/core/ipv4_longest_prefix_match_core_macros.svh -----
// Assertion macros for the route lookup core.
// Bodies are empty when SYNTHESIS is defined.
`ifndef IPV4_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH
`define IPV4_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LPM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpm assertion failed");

// Next-cycle implication.
`define LPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpm assertion failed");

`else

`define LPM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/lpm_pkg.sv -----
package lpm_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = 4;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] mask;
  } lpm_entry_t;

  typedef struct packed {
    logic             start;
    logic             eval;
    logic [IDX_W-1:0] idx;
  } lpm_scan_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } lpm_result_t;

  // Set-bit count of a 32-bit mask: per-byte counts, then a short sum.
  function automatic logic [LEN_W-1:0] count_ones(input logic [ADDR_W-1:0] v);
    logic [3:0] byte_cnt [4];
    logic [LEN_W-1:0] total;
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[8*b+i]);
      end
    end
    total = (LEN_W'(byte_cnt[0]) + LEN_W'(byte_cnt[1]))
          + (LEN_W'(byte_cnt[2]) + LEN_W'(byte_cnt[3]));
    return total;
  endfunction

endpackage

// ----- rtl/core/lpm_if.sv -----
interface lpm_req_if;
  import lpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [SLOT_W-1:0] entry_slot;
  logic [ADDR_W-1:0] route_network;
  logic [ADDR_W-1:0] route_mask;
  logic [ADDR_W-1:0] lookup_address;

  modport source (
    output valid, op, entry_slot, route_network, route_mask, lookup_address,
    input  ready
  );
  modport sink (
    input  valid, op, entry_slot, route_network, route_mask, lookup_address,
    output ready
  );
endinterface

interface lpm_rsp_if;
  import lpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] match_slot;
  logic [LEN_W-1:0]  prefix_length;

  modport source (
    output valid, found, match_slot, prefix_length,
    input  ready
  );
  modport sink (
    input  valid, found, match_slot, prefix_length,
    output ready
  );
endinterface

// ----- rtl/core/lpm_table.sv -----
module lpm_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [lpm_pkg::IDX_W-1:0] wr_idx,
  input  logic [lpm_pkg::ADDR_W-1:0] wr_network,
  input  logic [lpm_pkg::ADDR_W-1:0] wr_mask,
  input  logic                      rd_en,
  input  logic [lpm_pkg::IDX_W-1:0] rd_idx,
  output lpm_pkg::lpm_entry_t       rd_entry
);
  import lpm_pkg::*;

  logic [ADDR_W-1:0]  net_mem  [ENTRIES];
  logic [ADDR_W-1:0]  mask_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_bits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      net_mem[wr_idx]  <= wr_network;
      mask_mem[wr_idx] <= wr_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_idx] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry.valid   <= valid_bits[rd_idx];
      rd_entry.network <= net_mem[rd_idx];
      rd_entry.mask    <= mask_mem[rd_idx];
    end
  end

endmodule

// ----- rtl/core/lpm_match.sv -----
module lpm_match (
  input  logic                       clk,
  input  logic                       rst,
  input  lpm_pkg::lpm_scan_t         ctl,
  input  lpm_pkg::lpm_entry_t        entry,
  input  logic [lpm_pkg::ADDR_W-1:0] addr,
  output lpm_pkg::lpm_result_t       result
);
  import lpm_pkg::*;

  logic             hit;
  logic [IDX_W-1:0] best_idx;
  logic [LEN_W-1:0] best_len;
  logic [LEN_W-1:0] cand_len;
  logic             cand_hit;
  logic             take;

  assign cand_len = count_ones(entry.mask);
  assign cand_hit = entry.valid && ((addr & entry.mask) == entry.network);
  // strict compare keeps the lowest index on a tie
  assign take     = ctl.eval && cand_hit && (!hit || (cand_len > best_len));

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.start) begin
      hit <= 1'b0;
    end else if (take) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best_idx <= '0;
      best_len <= '0;
    end else if (take) begin
      best_idx <= ctl.idx;
      best_len <= cand_len;
    end
  end

  assign result.found = hit;
  assign result.slot  = SLOT_W'(best_idx);
  assign result.len   = best_len;

endmodule

// ----- rtl/core/ipv4_longest_prefix_match_core.sv -----
// Write beat: written to the table on acceptance, no response beat.
// Lookup beat: the table is scanned in ST_SCAN, then ST_DRAIN and ST_FINISH follow;
// the response register loads in ST_FINISH once the output is free, and no new
// request is taken until then. The single table read port visits one entry a cycle.
// rst (synchronous) clears all entry valid bits and the response valid flag.
`include "ipv4_longest_prefix_match_core_macros.svh"

module ipv4_longest_prefix_match_core (
  input logic clk,
  input logic rst,
  lpm_req_if.sink   req,
  lpm_rsp_if.source rsp
);
  import lpm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  cnt;
  logic [ADDR_W-1:0] addr;
  logic              eval_q;
  logic [IDX_W-1:0]  eval_idx_q;
  logic              accept;
  logic              wr_ok;
  logic              out_free;
  lpm_scan_t         scan_ctl;
  lpm_entry_t        rd_entry;
  lpm_result_t       result;
  lpm_result_t       rsp_q;
  logic              rsp_valid;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign out_free = !rsp_valid || rsp.ready;
  // slots past the table are dropped
  assign wr_ok    = accept && (req.op == OP_WRITE)
                 && (9'(req.entry_slot) < 9'(ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req.op == OP_LOOKUP)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == IDX_W'(ENTRIES - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      eval_q <= 1'b0;
    end else begin
      state  <= state_next;
      eval_q <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.op == OP_LOOKUP)) begin
      cnt  <= '0;
      addr <= req.lookup_address;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end
    eval_idx_q <= cnt;
  end

  lpm_table u_table (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_ok),
    .wr_idx     (IDX_W'(req.entry_slot)),
    .wr_network (req.route_network),
    .wr_mask    (req.route_mask),
    .rd_en      (state == ST_SCAN),
    .rd_idx     (cnt),
    .rd_entry   (rd_entry)
  );

  // compare runs in the cycle after the table read
  assign scan_ctl.start = accept && (req.op == OP_LOOKUP);
  assign scan_ctl.eval  = eval_q;
  assign scan_ctl.idx   = eval_idx_q;

  lpm_match u_match (
    .clk    (clk),
    .rst    (rst),
    .ctl    (scan_ctl),
    .entry  (rd_entry),
    .addr   (addr),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      rsp_q <= result;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.found         = rsp_q.found;
  assign rsp.match_slot    = rsp_q.slot;
  assign rsp.prefix_length = rsp_q.len;

  `LPM_ASSERT_NEXT(a_lookup_starts_scan, clk, rst, accept && (req.op == OP_LOOKUP),
                   (state == ST_SCAN) && (cnt == '0))
  `LPM_ASSERT_IMPL(a_busy_not_ready, clk, rst, state != ST_IDLE, !req.ready)
  `LPM_ASSERT_NEXT(a_finish_loads_rsp, clk, rst, (state == ST_FINISH) && out_free,
                   rsp.valid && (state == ST_IDLE))
  `LPM_ASSERT_IMPL(a_rsp_consistent, clk, rst, rsp.valid,
                   (rsp.prefix_length <= 6'd32) &&
                   (rsp.found || ((rsp.match_slot == 4'd0) && (rsp.prefix_length == 6'd0))))

endmodule

// ----- dv/lpm_route_checker.sv -----
module lpm_route_checker (
  input  logic        clk,
  input  logic        rst,
  lpm_req_if          req,
  lpm_rsp_if          rsp,
  output int unsigned mismatches,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpm_pkg::*;

  lpm_entry_t  route_table [ENTRIES];
  lpm_result_t expected_routes [$];
  int unsigned error_count;

  // Longest mask wins; strict compare keeps the lowest index on a tie.
  function automatic lpm_result_t best_route(input logic [ADDR_W-1:0] addr);
    lpm_result_t best;
    int unsigned len;
    best = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (route_table[i].valid && ((addr & route_table[i].mask) == route_table[i].network)) begin
        len = $countones(route_table[i].mask);
        if (!best.found || len > best.len) begin
          best.found = 1'b1;
          best.slot  = SLOT_W'(i);
          best.len   = LEN_W'(len);
        end
      end
    end
    return best;
  endfunction

  function automatic void log_error(input string what, input lpm_result_t want,
                                    input lpm_result_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected found=%0b slot=%0d len=%0d",
               want.found, want.slot, want.len);
      $display("  got      found=%0b slot=%0d len=%0d",
               got.found, got.slot, got.len);
    end
  endfunction

  always @(posedge clk) begin : monitor
    lpm_result_t got;
    lpm_result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) route_table[i].valid = 1'b0;
      expected_routes.delete();
      error_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.found, rsp.match_slot, rsp.prefix_length};
        if (expected_routes.size() == 0) begin
          log_error("response beat with no lookup outstanding", 'x, got);
        end else begin
          want = expected_routes.pop_front();
          if (got.found !== want.found || got.slot !== want.slot || got.len !== want.len)
            log_error("lookup result mismatch", want, got);
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_WRITE) begin
          if (req.entry_slot < ENTRIES) begin
            route_table[req.entry_slot].valid   = 1'b1;
            route_table[req.entry_slot].network = req.route_network;
            route_table[req.entry_slot].mask    = req.route_mask;
          end
        end else begin
          expected_routes.push_back(best_route(req.lookup_address));
        end
      end
    end
    mismatches <= error_count;
    pending    <= expected_routes.size();
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 1200;

  logic clk = 1'b0;
  logic rst;

  lpm_req_if req_if ();
  lpm_rsp_if rsp_if ();

  int unsigned mismatches;
  int unsigned pending_lookups;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_request;
  int unsigned quiet_cycles;

  // record of what was written, used only to aim lookups at real routes
  logic [ADDR_W-1:0] written_net  [16];
  logic [ADDR_W-1:0] written_mask [16];
  bit                written      [16];

  ipv4_longest_prefix_match_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  lpm_route_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .mismatches (mismatches),
    .pending    (pending_lookups)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
    return (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_mask();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return 32'hFFFF_FFFF;
    if (r < 85) return prefix_mask($urandom_range(32));
    return $urandom;
  endfunction

  // small pool of bases so that routes nest and overlap
  function automatic logic [ADDR_W-1:0] pick_base();
    logic [ADDR_W-1:0] base;
    case ($urandom_range(3))
      0:       base = 32'h0A01_0203;
      1:       base = 32'hC0A8_0101;
      2:       base = 32'hAC10_0000;
      default: base = 32'hFFFF_FF00;
    endcase
    return base ^ ($urandom >> $urandom_range(8, 31));
  endfunction

  task automatic offer_request(input logic op, input logic [SLOT_W-1:0] slot,
                               input logic [ADDR_W-1:0] net, input logic [ADDR_W-1:0] mask,
                               input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.op             <= op;
    req_if.entry_slot     <= slot;
    req_if.route_network  <= net;
    req_if.route_mask     <= mask;
    req_if.lookup_address <= addr;
    do @(posedge clk); while (!req_if.ready);
    if (op == OP_WRITE) begin
      written[slot]      = 1'b1;
      written_net[slot]  = net;
      written_mask[slot] = mask;
    end
  endtask

  task automatic write_route(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] net,
                             input logic [ADDR_W-1:0] mask);
    offer_request(OP_WRITE, slot, net, mask, $urandom);
  endtask

  task automatic lookup(input logic [ADDR_W-1:0] addr);
    offer_request(OP_LOOKUP, SLOT_W'($urandom), $urandom, $urandom, addr);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups != 0) @(posedge clk);
  endtask

  task automatic directed_items();
    lookup(32'h0000_0000);                        // empty table: no match
    lookup(32'hFFFF_FFFF);
    write_route(4'd3, 32'h0000_0000, 32'h0000_0000); // default route
    lookup(32'hC0A8_0101);
    write_route(4'd0, 32'h0A00_0000, 32'hFF00_0000);
    write_route(4'd15, 32'h0A01_0203, 32'hFFFF_FFFF);
    write_route(4'd9, 32'h0A01_0000, 32'hFFFF_0000);
    write_route(4'd12, 32'h0A00_0200, 32'hFF00_FF00); // split mask, ties with slot 9
    write_route(4'd7, 32'h0A01_0201, 32'hFFFF_FF00); // host bits set: never hits
    lookup(32'h0A01_0203);
    lookup(32'h0A01_0204);
    lookup(32'h0A01_02FF);
    lookup(32'h0A02_0000);
    lookup(32'h0B00_0000);
    write_route(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    lookup(32'hFFFF_FFFF);
    lookup(32'h0000_0000);
    write_route(4'd3, 32'h8000_0000, 32'h8000_0000);
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFF);
    write_route(4'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    lookup(32'h0000_0000);
    lookup(32'h0A01_0203);
  endtask

  task automatic random_request();
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    int unsigned       r;
    slot = SLOT_W'($urandom);
    if ($urandom_range(99) < 30) begin
      mask = pick_mask();
      net  = ($urandom_range(9) == 0) ? $urandom : (pick_base() & mask);
      write_route(slot, net, mask);
    end else begin
      r = $urandom_range(99);
      if (r < 60 && written[slot])
        addr = (written_net[slot] & written_mask[slot]) | ($urandom & ~written_mask[slot]);
      else if (r < 85)
        addr = pick_base();
      else
        addr = $urandom;
      lookup(addr);
    end
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) random_request();
  endtask

  // receiver side; a hold-off is counted here while the sender keeps going
  initial begin : receiver
    int unsigned hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left        = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    do begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end while (quiet_cycles < WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    rst                   = 1'b1;
    hold_off_request      = 1'b0;
    req_if.valid          = 1'b0;
    req_if.op             = OP_WRITE;
    req_if.entry_slot     = '0;
    req_if.route_network  = '0;
    req_if.route_mask     = '0;
    req_if.lookup_address = '0;
    for (int i = 0; i < 16; i++) written[i] = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 61;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    run_random(RANDOM_ITEMS / 3);
    drain();                                      // sender pauses until all results are in

    send_idle_pct = 61;
    recv_idle_pct = 15;
    run_random(RANDOM_ITEMS / 3);

    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_off_request = 1'b1;                      // block backs up and stalls its input
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain();
    repeat (ENTRIES + 6) @(posedge clk);

    if (mismatches == 0 && pending_lookups == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
